### rtl/core/fcbm_pkg.sv
// Package of the freezer cartridge bank mapper: command and source codes,
// request/result/state structs and the RAM and flash address helpers.
// No dependencies.
`default_nettype none
package fcbm_pkg;

  localparam int unsigned RAM_BYTES   = 32768;
  localparam int unsigned FLASH_BYTES = 131072;
  localparam int unsigned RAM_AW      = $clog2(RAM_BYTES);
  localparam int unsigned FLASH_AW    = $clog2(FLASH_BYTES);
  localparam int unsigned ADDR_W      = 13;

  // I/O page windows inside the 8 KB ROM space
  localparam logic [ADDR_W-1:0] IO1_WINDOW = 13'h1e00;
  localparam logic [ADDR_W-1:0] IO2_WINDOW = 13'h1f00;

  typedef enum logic [3:0] {
    CMD_IO1_RD   = 4'd0,
    CMD_IO1_WR   = 4'd1,
    CMD_IO2_RD   = 4'd2,
    CMD_IO2_WR   = 4'd3,
    CMD_ROML_RD  = 4'd4,
    CMD_ROML_WR  = 4'd5,
    CMD_ULTI_WR  = 4'd6,
    CMD_ROMH_RD  = 4'd7,
    CMD_ROMH_WR  = 4'd8,
    CMD_A0_RD    = 4'd9,
    CMD_A0_WR    = 4'd10,
    CMD_FREEZE   = 4'd11
  } cmd_e;

  typedef enum logic [1:0] {
    SRC_DATA    = 2'd0,
    SRC_FLASH   = 2'd1,
    SRC_DEFAULT = 2'd2,
    SRC_WRITE   = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    REG_FLASH_JUMPER = 2'd0,
    REG_BANK_JUMPER  = 2'd1,
    REG_NORDIC       = 2'd2
  } reg_e;

  // I/O page 1 register offsets
  localparam logic [7:0] IO1_CTRL = 8'h00;
  localparam logic [7:0] IO1_MODE = 8'h01;

  typedef struct packed {
    logic [3:0]        cmd;
    logic [ADDR_W-1:0] address;
    logic [7:0]        write_data;
    logic              freeze_armed;
  } item_t;

  typedef struct packed {
    logic flash_jumper;
    logic bank_jumper;
    logic nordic_variant;
  } cfg_t;

  typedef struct packed {
    logic [3:0] bank;
    logic       enabled;
    logic       frozen;
    logic       lock_written;
    logic       exrom;
    logic       game;
    logic       req_exrom;
    logic       req_game;
    logic       ram_mode;
    logic       power_mode;
    logic       allow_banking;
    logic       freeze_blocked;
    logic       io_remap;
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  typedef struct packed {
    logic [7:0]          read_data;
    logic                use_ram;
    src_e                src;
    logic [FLASH_AW-1:0] flash_address;
    logic                flash_write;
    logic                pass_write;
    logic                exrom;
    logic                game;
    logic                release_irq;
  } result_t;

  function automatic logic [RAM_AW-1:0] ram_index(input logic [ADDR_W-1:0] a,
                                                  input logic [3:0] bank,
                                                  input logic banked);
    logic [RAM_AW-1:0] r;
    r = {2'b00, a};
    if (banked) begin
      r = {bank[1:0], a};
    end
    return r;
  endfunction

  // Bank jumper off maps into the upper half of the flash only
  function automatic logic [FLASH_AW-1:0] flash_index(input logic [ADDR_W-1:0] a,
                                                      input logic [3:0] bank,
                                                      input logic full_flash,
                                                      input logic low_cleared);
    logic [3:0] b;
    logic [FLASH_AW-1:0] r;
    b = bank;
    if (low_cleared) begin
      b[1:0] = 2'b00;
    end
    if (full_flash) begin
      r = {b, a};
    end else begin
      r = {1'b1, b[2:0], a};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/fcbm_ram.sv
// Cartridge RAM with registered read data and a zeroing sweep after reset.
// Depends on fcbm_pkg.
`default_nettype none
module fcbm_ram (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fcbm_pkg::ram_req_t req_i,
  output logic [7:0]             rdata_o,
  output logic                   busy_o
);

  logic [7:0] mem [fcbm_pkg::RAM_BYTES];
  logic [fcbm_pkg::RAM_AW-1:0] clr_q;
  logic                        busy_q;
  logic [7:0]                  rdata_q;

  // sweep counter, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (&clr_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= 8'h00;
    end else if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule
`default_nettype wire

### rtl/core/fcbm_core.sv
// Mapper state registers, configuration registers and the access decode.
// Depends on fcbm_pkg.
`default_nettype none
module fcbm_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire fcbm_pkg::item_t   item_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic              cfg_data_i,
  output fcbm_pkg::result_t      res_o,
  output fcbm_pkg::ram_req_t     ram_req_o,
  output fcbm_pkg::state_t       st_o
);

  fcbm_pkg::state_t  st_q, st_d, nx;
  fcbm_pkg::cfg_t    cfg_q;
  fcbm_pkg::result_t res;
  fcbm_pkg::ram_req_t req;
  logic [7:0]        lo;
  logic [7:0]        v;
  logic [7:0]        status;
  logic [3:0]        wr_bank;
  logic              plain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (fcbm_pkg::reg_e'(cfg_idx_i))
        fcbm_pkg::REG_FLASH_JUMPER: cfg_q.flash_jumper   <= cfg_data_i;
        fcbm_pkg::REG_BANK_JUMPER:  cfg_q.bank_jumper    <= cfg_data_i;
        fcbm_pkg::REG_NORDIC:       cfg_q.nordic_variant <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    nx      = st_q;
    res     = '0;
    res.src = fcbm_pkg::SRC_DATA;
    req     = '0;
    plain   = 1'b0;
    lo      = item_i.address[7:0];
    v       = item_i.write_data;
    req.wdata = v;
    status  = {st_q.bank[2], st_q.io_remap, st_q.bank[3], st_q.bank[1:0],
               item_i.freeze_armed, st_q.allow_banking, cfg_q.flash_jumper};
    wr_bank = {1'b0, v[7], v[4:3]};

    case (fcbm_pkg::cmd_e'(item_i.cmd))
      fcbm_pkg::CMD_IO1_RD: begin
        if (st_q.enabled) begin
          if (lo == fcbm_pkg::IO1_CTRL || lo == fcbm_pkg::IO1_MODE) begin
            res.read_data = status;
          end else if (st_q.io_remap && !st_q.frozen) begin
            if (st_q.ram_mode) begin
              req.rd_en   = 1'b1;
              req.addr    = fcbm_pkg::ram_index(fcbm_pkg::IO1_WINDOW | {5'd0, lo},
                                                st_q.bank, st_q.allow_banking);
              res.use_ram = 1'b1;
            end else if (st_q.game) begin
              res.src = fcbm_pkg::SRC_FLASH;
              res.flash_address = fcbm_pkg::flash_index(fcbm_pkg::IO1_WINDOW | {5'd0, lo},
                                    st_q.bank, cfg_q.bank_jumper, 1'b0);
            end
          end
        end
      end
      fcbm_pkg::CMD_IO1_WR: begin
        res.src = fcbm_pkg::SRC_WRITE;
        if (st_q.enabled) begin
          if (lo == fcbm_pkg::IO1_CTRL) begin
            nx.exrom    = v[1];
            nx.game     = ~v[0];
            nx.bank     = wr_bank;
            nx.ram_mode = v[5];
            nx.power_mode = cfg_q.nordic_variant && !v[6] && v[5] && ~v[0] && v[1];
            if (nx.power_mode) begin
              nx.exrom = 1'b0;
              nx.game  = 1'b0;
            end
            if (v[6]) begin
              nx.frozen       = 1'b0;
              res.release_irq = 1'b1;
            end
            if (nx.frozen) begin
              nx.exrom = 1'b1;
              nx.game  = 1'b0;
            end
            if (cfg_q.flash_jumper) begin
              nx.req_game  = ~v[0];
              nx.req_exrom = v[1];
              nx.game      = 1'b1;
              nx.exrom     = 1'b1;
            end
            if (v[2]) begin
              nx.enabled = 1'b0;
              nx.exrom   = 1'b1;
              nx.game    = 1'b1;
            end
          end else if (lo == fcbm_pkg::IO1_MODE) begin
            nx.bank = {cfg_q.flash_jumper & cfg_q.bank_jumper & ~v[5], wr_bank[2:0]};
            if (cfg_q.flash_jumper || !st_q.lock_written) begin
              nx.lock_written   = 1'b1;
              nx.allow_banking  = v[1];
              nx.freeze_blocked = v[2];
              nx.io_remap       = ~cfg_q.flash_jumper & v[6];
            end
          end else if (st_q.io_remap && !st_q.frozen && st_q.ram_mode) begin
            req.wr_en = 1'b1;
            req.addr  = fcbm_pkg::ram_index(fcbm_pkg::IO1_WINDOW | {5'd0, lo},
                                            st_q.bank, st_q.allow_banking);
          end
        end
      end
      fcbm_pkg::CMD_IO2_RD: begin
        if (st_q.enabled && !st_q.io_remap && !st_q.frozen) begin
          if (st_q.ram_mode) begin
            req.rd_en   = 1'b1;
            req.addr    = fcbm_pkg::ram_index(fcbm_pkg::IO2_WINDOW | {5'd0, lo},
                                              st_q.bank, st_q.allow_banking);
            res.use_ram = 1'b1;
          end else if (st_q.game) begin
            res.src = fcbm_pkg::SRC_FLASH;
            res.flash_address = fcbm_pkg::flash_index(fcbm_pkg::IO2_WINDOW | {5'd0, lo},
                                  st_q.bank, cfg_q.bank_jumper, 1'b0);
          end
        end
      end
      fcbm_pkg::CMD_IO2_WR: begin
        res.src = fcbm_pkg::SRC_WRITE;
        if (st_q.enabled && !st_q.io_remap && !st_q.frozen && st_q.ram_mode) begin
          req.wr_en = 1'b1;
          req.addr  = fcbm_pkg::ram_index(fcbm_pkg::IO2_WINDOW | {5'd0, lo},
                                          st_q.bank, st_q.allow_banking);
        end
      end
      fcbm_pkg::CMD_ROML_RD: begin
        if (st_q.frozen) begin
          res.src = fcbm_pkg::SRC_DEFAULT;
        end else if (st_q.power_mode) begin
          res.src = fcbm_pkg::SRC_FLASH;
          res.flash_address = fcbm_pkg::flash_index(item_i.address, st_q.bank,
                                                    cfg_q.bank_jumper, 1'b0);
        end else if (st_q.ram_mode) begin
          req.rd_en   = 1'b1;
          req.addr    = fcbm_pkg::ram_index(item_i.address, st_q.bank, 1'b1);
          res.use_ram = 1'b1;
        end else if (!st_q.game && !st_q.exrom) begin
          res.src = fcbm_pkg::SRC_DEFAULT;
        end else begin
          res.src = fcbm_pkg::SRC_FLASH;
          res.flash_address = fcbm_pkg::flash_index(item_i.address, st_q.bank,
                                                    cfg_q.bank_jumper, 1'b0);
        end
      end
      fcbm_pkg::CMD_ROML_WR: begin
        res.src  = fcbm_pkg::SRC_WRITE;
        req.addr = fcbm_pkg::ram_index(item_i.address, st_q.bank, 1'b1);
        if (cfg_q.flash_jumper) begin
          if (st_q.ram_mode) begin
            req.wr_en = 1'b1;
          end else begin
            res.flash_write   = 1'b1;
            res.pass_write    = 1'b1;
            res.flash_address = fcbm_pkg::flash_index(item_i.address, st_q.bank,
                                                      cfg_q.bank_jumper, 1'b0);
          end
        end else begin
          req.wr_en      = cfg_q.nordic_variant & st_q.ram_mode;
          res.pass_write = 1'b1;
        end
      end
      fcbm_pkg::CMD_ULTI_WR: begin
        res.src  = fcbm_pkg::SRC_WRITE;
        req.addr = fcbm_pkg::ram_index(item_i.address, st_q.bank, 1'b1);
        if (st_q.ram_mode) begin
          req.wr_en = 1'b1;
        end else if (cfg_q.flash_jumper) begin
          res.flash_write   = 1'b1;
          res.flash_address = fcbm_pkg::flash_index(item_i.address, st_q.bank,
                                                    cfg_q.bank_jumper, 1'b0);
        end
      end
      fcbm_pkg::CMD_ROMH_RD: begin
        if (st_q.power_mode && !st_q.frozen) begin
          req.rd_en   = 1'b1;
          req.addr    = fcbm_pkg::ram_index(item_i.address, st_q.bank, st_q.allow_banking);
          res.use_ram = 1'b1;
        end else begin
          plain = st_q.power_mode ? st_q.allow_banking
                                  : (st_q.allow_banking || !st_q.ram_mode);
          res.src = fcbm_pkg::SRC_FLASH;
          res.flash_address = fcbm_pkg::flash_index(item_i.address, st_q.bank,
                                                    cfg_q.bank_jumper, !plain);
        end
      end
      fcbm_pkg::CMD_ROMH_WR: begin
        res.src = fcbm_pkg::SRC_WRITE;
        if (st_q.power_mode && !st_q.frozen) begin
          req.wr_en      = 1'b1;
          req.addr       = fcbm_pkg::ram_index(item_i.address, st_q.bank,
                                               st_q.allow_banking);
          res.pass_write = 1'b1;
        end
      end
      fcbm_pkg::CMD_A0_RD: begin
        if (st_q.power_mode && st_q.frozen) begin
          req.rd_en   = 1'b1;
          req.addr    = fcbm_pkg::ram_index(item_i.address, st_q.bank, st_q.allow_banking);
          res.use_ram = 1'b1;
        end else begin
          res.src = fcbm_pkg::SRC_DEFAULT;
        end
      end
      fcbm_pkg::CMD_A0_WR: begin
        res.src = fcbm_pkg::SRC_WRITE;
        if (st_q.power_mode && st_q.frozen) begin
          req.wr_en = 1'b1;
          req.addr  = fcbm_pkg::ram_index(item_i.address, st_q.bank, st_q.allow_banking);
        end
      end
      fcbm_pkg::CMD_FREEZE: begin
        if (!st_q.freeze_blocked) begin
          nx.frozen     = 1'b1;
          nx.enabled    = 1'b1;
          nx.bank       = 4'd0;
          nx.ram_mode   = 1'b0;
          nx.power_mode = 1'b0;
        end
      end
      default: begin
        res.src = fcbm_pkg::SRC_DEFAULT;
      end
    endcase

    res.exrom = nx.exrom;
    res.game  = nx.game;
  end

  // Pulling the flash jumper drops the write-once lock
  always_comb begin
    st_d = step_i ? nx : st_q;
    if (cfg_we_i && fcbm_pkg::reg_e'(cfg_idx_i) == fcbm_pkg::REG_FLASH_JUMPER
        && cfg_q.flash_jumper && !cfg_data_i) begin
      st_d.lock_written = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{enabled: 1'b1, game: 1'b1, req_game: 1'b1, default: '0};
    end else begin
      st_q <= st_d;
    end
  end

  assign res_o     = res;
  assign ram_req_o = '{rd_en: req.rd_en & step_i,
                       wr_en: req.wr_en & step_i,
                       addr:  req.addr,
                       wdata: req.wdata};
  assign st_o      = st_q;

endmodule
`default_nettype wire

### rtl/core/freezer_cartridge_bank_mapper_top.sv
// Top level of the freezer cartridge bank mapper: request and result stages,
// handshakes and checks. Depends on fcbm_pkg, fcbm_core and fcbm_ram.
//
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one bus access or freeze
//   event per request. Output channel (out_valid_o/out_ready_i) returns one
//   result per request, in order. Config channel (cfg_valid_i/cfg_ready_o)
//   writes the jumper registers by index; it is always ready and should only
//   be used while no request is in flight.
// Pipeline
//   A request waits in the input stage, where the access is decoded against
//   the mapper state and the RAM is read or written; its result is registered
//   into the result stage, which drives out_valid_o. One request per cycle
//   is sustained while out_ready_i is high; RAM read data lands with the
//   result register, and state updates take effect for the very next request.
// Reset
//   After rst_ni releases, the 32 KB cart RAM is swept to zero, one byte per
//   cycle, and in_ready_o stays low until the sweep ends. Config writes are
//   taken during the sweep.
// Stall
//   If out_ready_i is low the result holds, the input stage keeps at most one
//   more request, and in_ready_o drops once both stages are full.
`default_nettype none
module freezer_cartridge_bank_mapper_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // access requests
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [3:0]                    cmd_i,
  input  wire logic [fcbm_pkg::ADDR_W-1:0]   address_i,
  input  wire logic [7:0]                    write_data_i,
  input  wire logic                          freeze_armed_i,
  // results
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [7:0]                         read_data_o,
  output logic [1:0]                         data_source_o,
  output logic [fcbm_pkg::FLASH_AW-1:0]      flash_address_o,
  output logic                               flash_write_o,
  output logic                               pass_write_o,
  output logic                               exrom_line_o,
  output logic                               game_line_o,
  output logic                               release_interrupts_o,
  // config writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic                          cfg_data_i
);

  fcbm_pkg::item_t    s1_q;
  logic               s1_vld_q;
  fcbm_pkg::result_t  s2_q;
  logic               s2_vld_q;
  fcbm_pkg::result_t  res;
  fcbm_pkg::ram_req_t ram_req;
  fcbm_pkg::state_t   st;
  logic [7:0]         ram_rdata;
  logic               ram_busy;
  logic               step;
  logic               in_fire;

  // Input stage moves on when the result stage is free or being drained
  assign step       = s1_vld_q && (!s2_vld_q || out_ready_i);
  assign in_ready_o = !ram_busy && (!s1_vld_q || step);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_q <= 1'b1;
      end else if (step) begin
        s1_vld_q <= 1'b0;
      end
      if (step) begin
        s2_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        s2_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= '{cmd: cmd_i, address: address_i, write_data: write_data_i,
                freeze_armed: freeze_armed_i};
    end
    if (step) begin
      s2_q <= res;
    end
  end

  fcbm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (s1_q),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res),
    .ram_req_o  (ram_req),
    .st_o       (st)
  );

  fcbm_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata),
    .busy_o  (ram_busy)
  );

  // RAM data register is only loaded with the result, so it holds on a stall
  assign out_valid_o          = s2_vld_q;
  assign read_data_o          = s2_q.use_ram ? ram_rdata : s2_q.read_data;
  assign data_source_o        = s2_q.src;
  assign flash_address_o      = s2_q.flash_address;
  assign flash_write_o        = s2_q.flash_write;
  assign pass_write_o         = s2_q.pass_write;
  assign exrom_line_o         = s2_q.exrom;
  assign game_line_o          = s2_q.game;
  assign release_interrupts_o = s2_q.release_irq;

  // no request enters during the RAM sweep
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_busy |-> !in_ready_o)
    else $error("request accepted during RAM sweep");

  // only data reads carry a byte
  a_data_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_source_o != fcbm_pkg::SRC_DATA |-> read_data_o == 8'h00)
    else $error("read data on non-data result");

  // a flash strobe belongs to a write result
  a_flash_wr_is_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flash_write_o |-> data_source_o == fcbm_pkg::SRC_WRITE)
    else $error("flash strobe on non-write result");

  // an unblocked freeze takes effect for the next request
  a_freeze_sets_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && s1_q.cmd == fcbm_pkg::CMD_FREEZE && !st.freeze_blocked
    |=> st.frozen && st.enabled && st.bank == 4'd0)
    else $error("freeze did not take effect");

endmodule
`default_nettype wire
